[rtl/core/lgcw_pkg.sv]
// shared types, constants and codes for the line grid cell walker
package lgcw_pkg;

   localparam int BLOCK_SHIFT_DEF = 7;
   localparam int MAX_SIDE_DEF    = 32;

   localparam int FIELD_W     = 16;
   localparam int COORD_W     = 17;
   localparam int SIDE_W      = 6;
   localparam int INDEX_OUT_W = 10;
   localparam int CNT_W       = 6;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CNT_W-1:0] RESULT_LIMIT = 6'd63;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 3'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CUR,
      ST_END,
      ST_TOT,
      ST_DEC1,
      ST_DEC2,
      ST_WALK
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CUR,
      OP_END,
      OP_TOT,
      OP_DEC1,
      OP_DEC2,
      OP_STEP
   } op_type;

   typedef struct packed {
      logic   idle;
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic walk_exit;
   } status_type;

endpackage

[rtl/core/lgcw_mac.sv]
// shared multiply-accumulate unit: acc plus or minus a product or an addend
module lgcw_mac #(
   parameter int MA_W  = 17,
   parameter int MB_W  = 16,
   parameter int ACC_W = 31
) (
   input  logic                    op_mul,
   input  logic                    op_neg,
   input  logic signed [ACC_W-1:0] acc,
   input  logic signed [MA_W-1:0]  ma,
   input  logic        [MB_W-1:0]  mb,
   input  logic signed [ACC_W-1:0] ad,
   output logic signed [ACC_W-1:0] res
);

   localparam int PROD_W = MA_W + MB_W + 1;

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  term;

   always_comb begin
      prod = ma * $signed({1'b0, mb});
      term = op_mul ? ACC_W'(prod) : ad;
      res  = op_neg ? (acc - term) : (acc + term);
   end

endmodule

[rtl/core/lgcw_seq.sv]
// sequencer: setup steps on the shared unit, then the grid walk
module lgcw_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  lgcw_pkg::status_type   status,
   output lgcw_pkg::ctrl_type     ctrl
);

   lgcw_pkg::state_type state_ff;
   lgcw_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lgcw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lgcw_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lgcw_pkg::ST_CUR;
            end
         end
         lgcw_pkg::ST_CUR:  state_in = lgcw_pkg::ST_END;
         lgcw_pkg::ST_END:  state_in = lgcw_pkg::ST_TOT;
         lgcw_pkg::ST_TOT:  state_in = lgcw_pkg::ST_DEC1;
         lgcw_pkg::ST_DEC1: state_in = lgcw_pkg::ST_DEC2;
         lgcw_pkg::ST_DEC2: state_in = lgcw_pkg::ST_WALK;
         lgcw_pkg::ST_WALK: begin
            if (status.walk_exit) begin
               state_in = lgcw_pkg::ST_IDLE;
            end
         end
         default: state_in = lgcw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl.idle = 1'b0;
      ctrl.op   = lgcw_pkg::OP_NONE;
      case (state_ff)
         lgcw_pkg::ST_IDLE: ctrl.idle = 1'b1;
         lgcw_pkg::ST_CUR:  ctrl.op = lgcw_pkg::OP_CUR;
         lgcw_pkg::ST_END:  ctrl.op = lgcw_pkg::OP_END;
         lgcw_pkg::ST_TOT:  ctrl.op = lgcw_pkg::OP_TOT;
         lgcw_pkg::ST_DEC1: ctrl.op = lgcw_pkg::OP_DEC1;
         lgcw_pkg::ST_DEC2: ctrl.op = lgcw_pkg::OP_DEC2;
         lgcw_pkg::ST_WALK: ctrl.op = lgcw_pkg::OP_STEP;
         default: ctrl.op = lgcw_pkg::OP_NONE;
      endcase
   end

endmodule

[rtl/core/line_grid_cell_walker.sv]
// line grid cell walker top level: registers, datapath and result register
// setup steps CUR, END, TOT, DEC1 and DEC2, then one block per cycle unless rsp_stall
// a segment gives at most 63 results; req_stall holds the next until the walker is idle
// a segment whose start block index is outside the grid gives no result
// the walk loop is a single decision update on the shared multiply-accumulate unit
// reset: synchronous; origins go to zero, grid size to 32 by 32, walker to idle
module line_grid_cell_walker #(
   parameter int BLOCK_SHIFT     = lgcw_pkg::BLOCK_SHIFT_DEF,
   parameter int MAX_SIDE_BLOCKS = lgcw_pkg::MAX_SIDE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lgcw_pkg::FIELD_W-1:0]        req_line_id,
   input  logic signed [lgcw_pkg::FIELD_W-1:0] req_start_x,
   input  logic signed [lgcw_pkg::FIELD_W-1:0] req_start_y,
   input  logic signed [lgcw_pkg::FIELD_W-1:0] req_end_x,
   input  logic signed [lgcw_pkg::FIELD_W-1:0] req_end_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lgcw_pkg::INDEX_OUT_W-1:0]    rsp_block_index,
   output logic [lgcw_pkg::FIELD_W-1:0]        rsp_segment_id,
   output logic                                rsp_last,
   output logic                                rsp_overflow,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lgcw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lgcw_pkg::FIELD_W-1:0]        csr_data
);

   localparam int COORD_W = lgcw_pkg::COORD_W;
   localparam int FIELD_W = lgcw_pkg::FIELD_W;
   localparam int SIDE_W  = lgcw_pkg::SIDE_W;
   localparam int CNT_W   = lgcw_pkg::CNT_W;
   localparam int IDX_W   = COORD_W - BLOCK_SHIFT + 7;
   localparam int ACC_W   = 24 + BLOCK_SHIFT;
   localparam int MA_W    = COORD_W;

   // configuration
   logic signed [FIELD_W-1:0] origin_x_ff;
   logic signed [FIELD_W-1:0] origin_y_ff;
   logic [SIDE_W-1:0]         grid_width_ff;
   logic [SIDE_W-1:0]         grid_height_ff;
   logic [SIDE_W-1:0]         w_eff;
   logic [SIDE_W-1:0]         h_eff;

   // segment
   logic [FIELD_W-1:0]        id_ff;
   logic signed [COORD_W-1:0] x_ff;
   logic signed [COORD_W-1:0] y_ff;
   logic signed [COORD_W-1:0] ex_ff;
   logic signed [COORD_W-1:0] ey_ff;
   logic [FIELD_W-1:0]        adx_ff;
   logic [FIELD_W-1:0]        ady_ff;
   logic                      sx_neg_ff;
   logic                      sy_neg_ff;
   logic                      dx_zero_ff;
   logic                      dy_zero_ff;
   logic signed [COORD_W-1:0] x_in;
   logic signed [COORD_W-1:0] y_in;
   logic signed [COORD_W-1:0] ex_in;
   logic signed [COORD_W-1:0] ey_in;
   logic signed [COORD_W-1:0] dx_in;
   logic signed [COORD_W-1:0] dy_in;
   logic [COORD_W-1:0]        adx_full;
   logic [COORD_W-1:0]        ady_full;

   // walker
   logic signed [IDX_W-1:0]   cur_ff;
   logic signed [IDX_W-1:0]   end_ff;
   logic signed [IDX_W-1:0]   total_ff;
   logic signed [ACC_W-1:0]   dec_ff;
   logic [CNT_W-1:0]          cnt_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [lgcw_pkg::INDEX_OUT_W-1:0] rsp_index_ff;
   logic [FIELD_W-1:0]            rsp_id_ff;
   logic                          rsp_last_ff;
   logic                          rsp_ovf_ff;

   lgcw_pkg::ctrl_type   ctrl;
   lgcw_pkg::status_type status;

   // shared unit operands
   logic                      op_mul;
   logic                      op_neg;
   logic signed [ACC_W-1:0]   mac_acc;
   logic signed [MA_W-1:0]    mac_ma;
   logic [FIELD_W-1:0]        mac_mb;
   logic signed [ACC_W-1:0]   mac_ad;
   logic signed [ACC_W-1:0]   mac_res;

   logic signed [COORD_W-1:0] bx;
   logic signed [COORD_W-1:0] by;
   logic signed [COORD_W-1:0] ebx;
   logic signed [COORD_W-1:0] eby;
   logic [BLOCK_SHIFT-1:0]    oxp;
   logic [BLOCK_SHIFT-1:0]    oyp;

   logic                      req_fire;
   logic                      walking;
   logic                      rsp_free;
   logic                      in_range;
   logic                      at_end;
   logic                      go_x;
   logic                      neg_step;
   logic signed [IDX_W-1:0]   step_mag;
   logic signed [IDX_W-1:0]   next_idx;
   logic                      next_out;
   logic                      at_limit;
   logic                      emit;
   logic                      emit_last;
   logic                      emit_ovf;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         grid_width_ff  <= SIDE_W'(32);
         grid_height_ff <= SIDE_W'(32);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lgcw_pkg::CSR_ORIGIN_X:    origin_x_ff    <= csr_data;
            lgcw_pkg::CSR_ORIGIN_Y:    origin_y_ff    <= csr_data;
            lgcw_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_data[SIDE_W-1:0];
            lgcw_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_data[SIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (grid_width_ff == '0) begin
         w_eff = SIDE_W'(1);
      end else if (grid_width_ff > SIDE_W'(MAX_SIDE_BLOCKS)) begin
         w_eff = SIDE_W'(MAX_SIDE_BLOCKS);
      end else begin
         w_eff = grid_width_ff;
      end
      if (grid_height_ff == '0) begin
         h_eff = SIDE_W'(1);
      end else if (grid_height_ff > SIDE_W'(MAX_SIDE_BLOCKS)) begin
         h_eff = SIDE_W'(MAX_SIDE_BLOCKS);
      end else begin
         h_eff = grid_height_ff;
      end
   end

   lgcw_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   assign req_stall = !ctrl.idle;
   assign req_fire  = req_valid && ctrl.idle;
   assign walking   = (ctrl.op == lgcw_pkg::OP_STEP);

   // segment capture
   always_comb begin
      x_in  = COORD_W'(req_start_x) - COORD_W'(origin_x_ff);
      y_in  = COORD_W'(req_start_y) - COORD_W'(origin_y_ff);
      ex_in = COORD_W'(req_end_x) - COORD_W'(origin_x_ff);
      ey_in = COORD_W'(req_end_y) - COORD_W'(origin_y_ff);
      dx_in = COORD_W'(req_end_x) - COORD_W'(req_start_x);
      dy_in = COORD_W'(req_end_y) - COORD_W'(req_start_y);
      adx_full = dx_in[COORD_W-1] ? COORD_W'(-dx_in) : COORD_W'(dx_in);
      ady_full = dy_in[COORD_W-1] ? COORD_W'(-dy_in) : COORD_W'(dy_in);
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         id_ff      <= req_line_id;
         x_ff       <= x_in;
         y_ff       <= y_in;
         ex_ff      <= ex_in;
         ey_ff      <= ey_in;
         adx_ff     <= adx_full[FIELD_W-1:0];
         ady_ff     <= ady_full[FIELD_W-1:0];
         sx_neg_ff  <= dx_in[COORD_W-1];
         sy_neg_ff  <= dy_in[COORD_W-1];
         dx_zero_ff <= (dx_in == '0);
         dy_zero_ff <= (dy_in == '0);
      end
   end

   // block coordinates and in-block distance to the far edge
   always_comb begin
      bx  = x_ff >>> BLOCK_SHIFT;
      by  = y_ff >>> BLOCK_SHIFT;
      ebx = ex_ff >>> BLOCK_SHIFT;
      eby = ey_ff >>> BLOCK_SHIFT;
      oxp = sx_neg_ff ? x_ff[BLOCK_SHIFT-1:0] : ~x_ff[BLOCK_SHIFT-1:0];
      oyp = sy_neg_ff ? y_ff[BLOCK_SHIFT-1:0] : ~y_ff[BLOCK_SHIFT-1:0];
   end

   // walk step
   always_comb begin
      rsp_free = !rsp_valid_ff || !rsp_stall;
      in_range = !cur_ff[IDX_W-1] && (cur_ff < total_ff);
      at_end   = (cur_ff == end_ff);
      go_x     = dec_ff[ACC_W-1];
      step_mag = go_x ? IDX_W'(1) : IDX_W'(w_eff);
      neg_step = go_x ? sx_neg_ff : sy_neg_ff;
      next_idx = neg_step ? (cur_ff - step_mag) : (cur_ff + step_mag);
      next_out = next_idx[IDX_W-1] || (next_idx >= total_ff);
      at_limit = (cnt_ff >= (lgcw_pkg::RESULT_LIMIT - CNT_W'(1)));
      emit      = walking && in_range && rsp_free;
      emit_last = at_end || next_out || at_limit;
      emit_ovf  = !at_end && !next_out && at_limit;
      status.walk_exit = walking && (!in_range || (emit && emit_last));
   end

   // shared unit operand select
   always_comb begin
      op_mul  = 1'b1;
      op_neg  = 1'b0;
      mac_acc = '0;
      mac_ma  = '0;
      mac_mb  = '0;
      mac_ad  = '0;
      case (ctrl.op)
         lgcw_pkg::OP_CUR: begin
            mac_acc = ACC_W'(bx);
            mac_ma  = by;
            mac_mb  = FIELD_W'(w_eff);
         end
         lgcw_pkg::OP_END: begin
            mac_acc = ACC_W'(ebx);
            mac_ma  = eby;
            mac_mb  = FIELD_W'(w_eff);
         end
         lgcw_pkg::OP_TOT: begin
            mac_ma = MA_W'(w_eff);
            mac_mb = FIELD_W'(h_eff);
         end
         lgcw_pkg::OP_DEC1: begin
            mac_ma = MA_W'(oxp);
            mac_mb = ady_ff;
         end
         lgcw_pkg::OP_DEC2: begin
            op_neg  = 1'b1;
            mac_acc = dec_ff;
            mac_ma  = MA_W'(oyp);
            mac_mb  = adx_ff;
         end
         lgcw_pkg::OP_STEP: begin
            op_mul  = 1'b0;
            op_neg  = !go_x;
            mac_acc = dec_ff;
            mac_ad  = ACC_W'({1'b0, (go_x ? ady_ff : adx_ff), {BLOCK_SHIFT{1'b0}}});
         end
         default: op_mul = 1'b1;
      endcase
   end

   lgcw_mac #(
      .MA_W  (MA_W),
      .MB_W  (FIELD_W),
      .ACC_W (ACC_W)
   ) u_mac (
      .op_mul (op_mul),
      .op_neg (op_neg),
      .acc    (mac_acc),
      .ma     (mac_ma),
      .mb     (mac_mb),
      .ad     (mac_ad),
      .res    (mac_res)
   );

   // walker state
   always_ff @(posedge clock) begin
      case (ctrl.op)
         lgcw_pkg::OP_CUR: cur_ff   <= IDX_W'(mac_res);
         lgcw_pkg::OP_END: end_ff   <= IDX_W'(mac_res);
         lgcw_pkg::OP_TOT: total_ff <= IDX_W'(mac_res);
         lgcw_pkg::OP_DEC1: dec_ff  <= mac_res;
         lgcw_pkg::OP_DEC2: begin
            if (dx_zero_ff) begin
               dec_ff <= ACC_W'(1);
            end else if (dy_zero_ff) begin
               dec_ff <= '1;
            end else begin
               dec_ff <= mac_res;
            end
         end
         lgcw_pkg::OP_STEP: begin
            if (emit) begin
               dec_ff <= mac_res;
               cur_ff <= next_idx;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (req_fire) begin
         cnt_ff <= '0;
      end else if (emit) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_index_ff <= cur_ff[lgcw_pkg::INDEX_OUT_W-1:0];
         rsp_id_ff    <= id_ff;
         rsp_last_ff  <= emit_last;
         rsp_ovf_ff   <= emit_ovf;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_segment_id  = rsp_id_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule
